>>> hdl/rgbhsl_pkg.sv
package rgbhsl_pkg;

  localparam int CH_W               = 8;
  localparam int HUE_W              = 16;
  localparam int SAT_W              = 17;
  localparam int LIG_W              = 17;
  localparam int FRACTION_BITS_DEF  = 16;

  localparam int SUM_W  = CH_W + 1;
  localparam int HDEN_W = CH_W + 3;
  localparam int SDEN_W = CH_W;
  localparam int LDEN_W = SUM_W;

  localparam logic [SUM_W-1:0]  HALF_SUM = 9'd255;
  localparam logic [LDEN_W-1:0] LIG_DEN  = 9'd510;

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } max_sel_t;

endpackage

>>> hdl/rgbhsl_div.sv
module rgbhsl_div #(
  parameter int W  = 8,
  parameter int QW = 18
) (
  input  logic          clk,
  input  logic          en,
  input  logic [W-1:0]  num,
  input  logic [W-1:0]  den,
  output logic [QW-1:0] quo
);

  logic [W-1:0]  rem_s [QW];
  logic [W-1:0]  den_s [QW];
  logic [QW-1:0] quo_s [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [W:0]    part;
    logic [W-1:0]  dsrc;
    logic [QW-1:0] qprev;
    logic [W:0]    diff;
    logic          qbit;

    if (k == 0) begin : g_first
      assign part  = {1'b0, num};
      assign dsrc  = den;
      assign qprev = '0;
    end else begin : g_next
      assign part  = {rem_s[k-1], 1'b0};
      assign dsrc  = den_s[k-1];
      assign qprev = quo_s[k-1];
    end

    assign diff = part - {1'b0, dsrc};
    assign qbit = (part >= {1'b0, dsrc});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k] <= qbit ? diff[W-1:0] : part[W-1:0];
        den_s[k] <= dsrc;
        quo_s[k] <= {qprev[QW-2:0], qbit};
      end
    end
  end

  assign quo = quo_s[QW-1];

endmodule

>>> hdl/rgb_to_hsl_convert.sv
// RGB to HSL converter for an ARGB pixel stream.
// The input channel carries one pixel per beat (alpha_in, red_in, green_in,
// blue_in) under in_valid/in_ready. The output channel carries one result
// per beat (alpha_out, hue, saturation, lightness) under out_valid/out_ready,
// in input order. Hue is a fraction of a turn, saturation and lightness run
// from 0 to 1, all with FRACTION_BITS fraction bits and rounded to nearest.
// Hue and saturation come from restoring dividers that resolve one quotient
// bit per pipeline stage; lightness divides by a constant and takes a
// reciprocal multiply with a small correction alongside them. The converter
// takes one pixel per cycle while the receiver does not stall.
// Reset clears every valid bit; in_ready is high from the first cycle after
// reset. When the receiver stalls, the whole pipeline holds and the output
// keeps its beat; a one-entry skid buffer takes one more input beat, then
// in_ready drops and comes back in the cycle after the stall clears.
module rgb_to_hsl_convert #(
  parameter int FRACTION_BITS = rgbhsl_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rgbhsl_pkg::CH_W-1:0]   alpha_in,
  input  logic [rgbhsl_pkg::CH_W-1:0]   red_in,
  input  logic [rgbhsl_pkg::CH_W-1:0]   green_in,
  input  logic [rgbhsl_pkg::CH_W-1:0]   blue_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rgbhsl_pkg::CH_W-1:0]   alpha_out,
  output logic [rgbhsl_pkg::HUE_W-1:0]  hue,
  output logic [rgbhsl_pkg::SAT_W-1:0]  saturation,
  output logic [rgbhsl_pkg::LIG_W-1:0]  lightness
);
  import rgbhsl_pkg::*;

  localparam int QW     = FRACTION_BITS + 2;
  localparam int LQ_W   = FRACTION_BITS + 1;
  localparam int LIG_SH = LDEN_W;
  localparam int LP_W   = LDEN_W + LQ_W;
  localparam int LR_W   = FRACTION_BITS + LDEN_W + 1;
  localparam logic [LQ_W-1:0] LIG_RECIP =
    LQ_W'((64'd1 << (FRACTION_BITS + LIG_SH)) / 64'(LIG_DEN));

  logic en;

  logic            skid_v;
  logic [CH_W-1:0] skid_a, skid_r, skid_g, skid_b;

  logic            src_v;
  logic [CH_W-1:0] src_a, src_r, src_g, src_b;
  max_sel_t        sel_next;
  logic [CH_W-1:0] mx, mn;

  logic             v1;
  logic [CH_W-1:0]  a1, r1, g1, b1, delta1;
  logic [SUM_W-1:0] sum1;
  max_sel_t         sel1;

  logic [HDEN_W-1:0] d6, hnum_next;
  logic [SDEN_W-1:0] sden_next;

  logic              v2, grey2;
  logic [CH_W-1:0]   a2;
  logic [HDEN_W-1:0] hnum2, hden2;
  logic [SDEN_W-1:0] snum2, sden2;
  logic [SUM_W-1:0]  lnum2;

  logic [LP_W-1:0]   lprod;
  logic [LQ_W-1:0]   lest0, lest1, lig_next;
  logic [LDEN_W-1:0] lsum0;
  logic [LR_W-1:0]   lrem_next, lrem1;
  logic [LQ_W-1:0]   ld [2:QW-1];

  logic            vd [QW];
  logic            gd [QW];
  logic [CH_W-1:0] ad [QW];

  logic [QW-1:0] hq, sq;
  logic [QW-1:0] h_inc, s_inc;

  assign en       = !out_valid || out_ready;
  assign in_ready = !skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (en) begin
      skid_v <= 1'b0;
    end else if (in_valid && !skid_v) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_valid && !skid_v) begin
      skid_a <= alpha_in;
      skid_r <= red_in;
      skid_g <= green_in;
      skid_b <= blue_in;
    end
  end

  always_comb begin
    src_v = skid_v || in_valid;
    src_a = skid_v ? skid_a : alpha_in;
    src_r = skid_v ? skid_r : red_in;
    src_g = skid_v ? skid_g : green_in;
    src_b = skid_v ? skid_b : blue_in;
    if (src_r >= src_g && src_r >= src_b) begin
      sel_next = MAX_RED;
      mx       = src_r;
    end else if (src_g >= src_b) begin
      sel_next = MAX_GREEN;
      mx       = src_g;
    end else begin
      sel_next = MAX_BLUE;
      mx       = src_b;
    end
    mn = src_r;
    if (src_g < mn) mn = src_g;
    if (src_b < mn) mn = src_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= src_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1     <= src_a;
      r1     <= src_r;
      g1     <= src_g;
      b1     <= src_b;
      sel1   <= sel_next;
      delta1 <= mx - mn;
      sum1   <= {1'b0, mx} + {1'b0, mn};
    end
  end

  always_comb begin
    d6 = HDEN_W'({delta1, 2'b00}) + HDEN_W'({delta1, 1'b0});
    case (sel1)
      MAX_RED: begin
        if (g1 >= b1) begin
          hnum_next = HDEN_W'(g1) - HDEN_W'(b1);
        end else begin
          hnum_next = d6 + HDEN_W'(g1) - HDEN_W'(b1);
        end
      end
      MAX_GREEN: hnum_next = HDEN_W'({delta1, 1'b0}) + HDEN_W'(b1) - HDEN_W'(r1);
      MAX_BLUE:  hnum_next = HDEN_W'({delta1, 2'b00}) + HDEN_W'(r1) - HDEN_W'(g1);
      default:   hnum_next = '0;
    endcase
    if (sum1 < HALF_SUM) begin
      sden_next = sum1[SDEN_W-1:0];
    end else begin
      sden_next = SDEN_W'(LIG_DEN - sum1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a2    <= a1;
      grey2 <= (delta1 == '0);
      hnum2 <= hnum_next;
      hden2 <= d6;
      snum2 <= delta1;
      sden2 <= sden_next;
      lnum2 <= sum1;
    end
  end

  rgbhsl_div #(.W(HDEN_W), .QW(QW)) u_hue_div (
    .clk (clk),
    .en  (en),
    .num (hnum2),
    .den (hden2),
    .quo (hq)
  );

  rgbhsl_div #(.W(SDEN_W), .QW(QW)) u_sat_div (
    .clk (clk),
    .en  (en),
    .num (snum2),
    .den (sden2),
    .quo (sq)
  );

  // The reciprocal estimate falls short of the rounded quotient by at most
  // two, and the remainder against the divisor says by how much.
  assign lprod = LP_W'(lnum2) * LP_W'(LIG_RECIP);

  always_comb begin
    lrem_next = {1'b0, lsum0, {FRACTION_BITS{1'b0}}} + LR_W'(HALF_SUM)
                - LR_W'(lest0) * LR_W'(LIG_DEN);
    if (lrem1 >= LR_W'({LIG_DEN, 1'b0})) begin
      lig_next = lest1 + LQ_W'(2);
    end else if (lrem1 >= LR_W'(LIG_DEN)) begin
      lig_next = lest1 + LQ_W'(1);
    end else begin
      lig_next = lest1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lest0 <= lprod[LP_W-1:LIG_SH];
      lsum0 <= lnum2;
      lest1 <= lest0;
      lrem1 <= lrem_next;
      ld[2] <= lig_next;
      for (int k = 3; k < QW; k++) begin
        ld[k] <= ld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QW; k++) begin
        vd[k] <= 1'b0;
      end
    end else if (en) begin
      vd[0] <= v2;
      for (int k = 1; k < QW; k++) begin
        vd[k] <= vd[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gd[0] <= grey2;
      ad[0] <= a2;
      for (int k = 1; k < QW; k++) begin
        gd[k] <= gd[k-1];
        ad[k] <= ad[k-1];
      end
    end
  end

  // The dividers return one extra fraction bit; adding one and dropping it
  // rounds to nearest with halves going up.
  assign h_inc = hq + 1'b1;
  assign s_inc = sq + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vd[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      alpha_out  <= ad[QW-1];
      hue        <= gd[QW-1] ? '0 : HUE_W'(h_inc[FRACTION_BITS:1]);
      saturation <= gd[QW-1] ? '0 : SAT_W'(s_inc[QW-1:1]);
      lightness  <= LIG_W'(ld[QW-1]);
    end
  end

endmodule

>>> hdl/rgbhsl_check.sv
module rgbhsl_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rgbhsl_pkg::CH_W-1:0]   alpha_out,
  input logic [rgbhsl_pkg::HUE_W-1:0]  hue,
  input logic [rgbhsl_pkg::SAT_W-1:0]  saturation,
  input logic [rgbhsl_pkg::LIG_W-1:0]  lightness
);
  import rgbhsl_pkg::*;

  // A beat that the receiver stalls stays on the output unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(alpha_out) && $stable(hue)
      && $stable(saturation) && $stable(lightness))
    else $error("output beat changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // Input backpressure only follows an output stall in the previous cycle.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("in_ready low without an output stall");

  // While the output flows freely, no input beat is refused.
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    $past(!out_valid || out_ready) && !$past(rst) |-> in_ready)
    else $error("in_ready low while the pipeline advances");

endmodule

bind rgb_to_hsl_convert rgbhsl_check u_check (.*);
